/* sv/i7s_pkg.sv */
`default_nettype none

package i7s_pkg;

    localparam int          DIGIT_COUNT = 4;
    localparam logic [7:0]  VALUE_BASE  = 8'h10;
    localparam logic [7:0]  POINT_REG   = 8'h12;
    localparam logic [7:0]  POINT_RESET = 8'hFF;
    localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;
    localparam int          QUOT_W      = 32 - DIV10_SHIFT;

    typedef enum logic [2:0] {
        REQ_ADDR  = 3'd0,
        REQ_WRITE = 3'd1,
        REQ_READ  = 3'd2,
        REQ_STOP  = 3'd3,
        REQ_SCAN  = 3'd4
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_CV_HI,
        ST_CV_LO,
        ST_CV_PT,
        ST_CV_OLD,
        ST_DIV,
        ST_DIGIT,
        ST_THOU,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } wr_t;

    function automatic logic [6:0] seg_pattern(input logic [3:0] d);
        logic [6:0] p;
        case (d)
            4'd0:    p = 7'b0111111;
            4'd1:    p = 7'b0000110;
            4'd2:    p = 7'b1011011;
            4'd3:    p = 7'b1001111;
            4'd4:    p = 7'b1100110;
            4'd5:    p = 7'b1101101;
            4'd6:    p = 7'b1111101;
            4'd7:    p = 7'b0000111;
            4'd8:    p = 7'b1111111;
            4'd9:    p = 7'b1101111;
            default: p = 7'b0000000;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] reset_value(input logic [7:0] addr);
        return (addr == POINT_REG) ? POINT_RESET : 8'h00;
    endfunction

endpackage

`default_nettype wire

/* sv/i2c_seven_segment_register_target_core.sv */
// channel  | valid/ready       | tdata                         | tuser
// s_       | s_tvalid/s_tready | [7:0] data_byte               | [2:0] req_type
// m_       | m_tvalid/m_tready | [7:0] read_data, [15:8] segs  | [1:0] digit_index, [2] updated
//
// Address match, write, stop without update and unknown kinds: straight from idle to result.
// Read and scan tick: an extra state waits on the registered read port of the register file.
// Stop with update: four reads, then three passes through the shared divide-by-ten unit.
// s_tready is high only while idle; a result waiting on m_tready holds the next result back.
// Reset clears control state; register file entries read as reset values until written.
`default_nettype none

module i2c_seven_segment_register_target_core
    import i7s_pkg::*;
#(
    parameter int REG_COUNT = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [2:0]  s_tuser,   // [2:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [7:0] read_data, [15:8] segment_bits
    output logic      [2:0]  m_tuser    // [1:0] digit_index, [2] display_updated
);

    state_t            state_reg, state_next;
    logic [7:0]        ptr_reg, ptr_next;
    logic [7:0]        start_reg, start_next;
    logic [7:0]        cnt_reg, cnt_next;
    logic              expect_reg, expect_next;
    logic              seen_reg, seen_next;
    logic [1:0]        scan_reg, scan_next;
    logic [15:0]       cur_reg, cur_next;
    logic [7:0]        point_reg, point_next;
    logic [6:0]        old3_reg, old3_next;
    logic [1:0]        dig_reg, dig_next;
    logic [7:0]        res_rd_reg, res_rd_next;
    logic [7:0]        res_seg_reg, res_seg_next;
    logic [1:0]        res_didx_reg, res_didx_next;
    logic              res_upd_reg, res_upd_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg, m_tdata_next;
    logic [2:0]        m_tuser_reg, m_tuser_next;

    wr_t               wr;
    logic [7:0]        raddr;
    logic [7:0]        rdata;
    logic              div_load;
    logic [QUOT_W-1:0] div_q;
    logic [3:0]        div_r;
    logic              ptr_in_range;
    logic [7:0]        ptr_bumped;
    logic              dp;
    logic              blank;

    i7s_regfile #(
        .REG_COUNT(REG_COUNT)
    ) u_regfile (
        .clk  (clk),
        .rst_n(rst_n),
        .wr   (wr),
        .raddr(raddr),
        .rdata(rdata)
    );

    i7s_div10 u_div10 (
        .clk (clk),
        .load(div_load),
        .x   (cur_reg),
        .q   (div_q),
        .r   (div_r)
    );

    assign ptr_in_range = ({1'b0, ptr_reg} < 9'(REG_COUNT));
    assign ptr_bumped   = (ptr_reg == 8'hFF) ? ptr_reg : ptr_reg + 8'd1;
    assign dp           = (point_reg == {6'b000000, dig_reg});
    assign blank        = (dig_reg != 2'd0) && (cur_reg == 16'd0);
    assign div_load     = (state_reg == ST_DIV);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ptr_reg      <= 8'd0;
            start_reg    <= 8'd0;
            cnt_reg      <= 8'd0;
            expect_reg   <= 1'b1;
            seen_reg     <= 1'b0;
            scan_reg     <= 2'd0;
            dig_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            start_reg    <= start_next;
            cnt_reg      <= cnt_next;
            expect_reg   <= expect_next;
            seen_reg     <= seen_next;
            scan_reg     <= scan_next;
            dig_reg      <= dig_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        point_reg    <= point_next;
        old3_reg     <= old3_next;
        res_rd_reg   <= res_rd_next;
        res_seg_reg  <= res_seg_next;
        res_didx_reg <= res_didx_next;
        res_upd_reg  <= res_upd_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        start_next    = start_reg;
        cnt_next      = cnt_reg;
        expect_next   = expect_reg;
        seen_next     = seen_reg;
        scan_next     = scan_reg;
        cur_next      = cur_reg;
        point_next    = point_reg;
        old3_next     = old3_reg;
        dig_next      = dig_reg;
        res_rd_next   = res_rd_reg;
        res_seg_next  = res_seg_reg;
        res_didx_next = res_didx_reg;
        res_upd_next  = res_upd_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        wr            = '0;
        raddr         = 8'd0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_rd_next   = 8'd0;
                    res_seg_next  = 8'd0;
                    res_didx_next = 2'd0;
                    res_upd_next  = 1'b0;
                    state_next    = ST_DONE;
                    case (s_tuser)
                        REQ_ADDR:
                        begin
                            expect_next = 1'b1;
                            seen_next   = 1'b0;
                        end
                        REQ_WRITE:
                        begin
                            if (expect_reg)
                            begin
                                ptr_next    = s_tdata;
                                start_next  = s_tdata;
                                cnt_next    = 8'd0;
                                expect_next = 1'b0;
                                seen_next   = 1'b1;
                            end
                            else if (ptr_in_range)
                            begin
                                wr.en    = 1'b1;
                                wr.addr  = ptr_reg;
                                wr.data  = s_tdata;
                                ptr_next = ptr_bumped;
                                if (cnt_reg != 8'hFF)
                                begin
                                    cnt_next = cnt_reg + 8'd1;
                                end
                            end
                        end
                        REQ_READ:
                        begin
                            raddr      = ptr_reg;
                            state_next = ST_READ;
                        end
                        REQ_STOP:
                        begin
                            seen_next   = 1'b0;
                            expect_next = 1'b1;
                            if (seen_reg && (start_reg == VALUE_BASE) && (cnt_reg != 8'd0))
                            begin
                                raddr      = VALUE_BASE;
                                state_next = ST_CV_HI;
                            end
                        end
                        REQ_SCAN:
                        begin
                            raddr      = {6'b000000, scan_reg};
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_rd_next = ptr_in_range ? rdata : 8'd0;
                ptr_next    = ptr_bumped;
                state_next  = ST_DONE;
            end
            ST_SCAN:
            begin
                res_seg_next  = rdata;
                res_didx_next = scan_reg;
                scan_next     = scan_reg + 2'd1;
                state_next    = ST_DONE;
            end
            ST_CV_HI:
            begin
                cur_next[15:8] = rdata;
                raddr          = VALUE_BASE + 8'd1;
                state_next     = ST_CV_LO;
            end
            ST_CV_LO:
            begin
                cur_next[7:0] = rdata;
                raddr         = POINT_REG;
                state_next    = ST_CV_PT;
            end
            ST_CV_PT:
            begin
                point_next = rdata;
                raddr      = 8'(DIGIT_COUNT - 1);
                state_next = ST_CV_OLD;
            end
            ST_CV_OLD:
            begin
                old3_next  = rdata[6:0];
                dig_next   = 2'd0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                wr.en    = 1'b1;
                wr.addr  = {6'b000000, dig_reg};
                wr.data  = {dp, blank ? 7'd0 : seg_pattern(div_r)};
                cur_next = {{(16 - QUOT_W){1'b0}}, div_q};
                dig_next = dig_reg + 2'd1;
                if (dig_reg == 2'(DIGIT_COUNT - 2))
                begin
                    state_next = ST_THOU;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_THOU:
            begin
                wr.en   = 1'b1;
                wr.addr = 8'(DIGIT_COUNT - 1);
                if (cur_reg == 16'd0)
                begin
                    wr.data[6:0] = 7'd0;
                end
                else if (cur_reg < 16'd10)
                begin
                    wr.data[6:0] = seg_pattern(cur_reg[3:0]);
                end
                else
                begin
                    wr.data[6:0] = old3_reg;
                end
                wr.data[7]   = (point_reg == 8'(DIGIT_COUNT - 1));
                res_upd_next = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_seg_reg, res_rd_reg};
                    m_tuser_next  = {res_upd_reg, res_didx_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/i7s_div10.sv */
`default_nettype none

module i7s_div10
    import i7s_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              load,
    input  wire logic [15:0]       x,
    output logic      [QUOT_W-1:0] q,
    output logic      [3:0]        r
);

    logic [15:0]       x_reg;
    logic [QUOT_W-1:0] q_reg;
    logic [31:0]       prod;
    logic [15:0]       q_ten;
    logic [15:0]       diff;

    assign prod = x * DIV10_MUL;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= x;
            q_reg <= prod[31:DIV10_SHIFT];
        end
    end

    assign q_ten = {q_reg, 3'b000} + {2'b00, q_reg, 1'b0};
    assign diff  = x_reg - q_ten;
    assign q     = q_reg;
    assign r     = diff[3:0];

endmodule

`default_nettype wire

/* sv/i7s_regfile.sv */
`default_nettype none

module i7s_regfile
    import i7s_pkg::*;
#(
    parameter int REG_COUNT = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire wr_t        wr,
    input  wire logic [7:0] raddr,
    output logic      [7:0] rdata
);

    localparam int ADDR_W = $clog2(REG_COUNT);

    logic [7:0] mem [REG_COUNT];
    logic       valid_reg [REG_COUNT];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr[ADDR_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[ADDR_W-1:0]] <= wr.data;
        end
        rdata_reg <= valid_reg[raddr[ADDR_W-1:0]] ? mem[raddr[ADDR_W-1:0]]
                                                  : reset_value(raddr);
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/i7s_checker.sv */
`default_nettype none

module i7s_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic [2:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    logic in_beat;

    assign in_beat = s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tuser == s_tuser);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // drop ready for the beat just taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready)
        else $error("ready stayed high after an accepted beat");

    a_read_scan_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] == 8'd0) || (m_tdata[15:8] == 8'd0 && m_tuser[1:0] == 2'd0))
        else $error("read data and segment data in one result");

    a_update_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> (m_tdata == 16'd0) && (m_tuser[1:0] == 2'd0))
        else $error("update result carries data");

endmodule

bind i2c_seven_segment_register_target_core i7s_checker u_checker (.*);

`default_nettype wire

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import i7s_pkg::*;

    localparam int         LIMIT_CYCLES  = 500000;
    localparam int         RANDOM_ITEMS  = 500;
    localparam int         FILE_DEPTH    = 32;
    localparam int         DRAIN_CYCLES  = 30;
    localparam logic [2:0] REQ_UNUSED    = 3'd7;
    localparam logic [7:0] PTR_TOP       = 8'hFF;
    localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] digit_index;
        logic [7:0] segment_bits;
        logic       display_updated;
    } display_beat_t;

    typedef struct packed {
        logic [2:0]    req;
        logic [7:0]    data;
        logic          fixed;
        display_beat_t res;
    } bus_event_t;

    localparam display_beat_t QUIET   = '0;
    localparam display_beat_t READ_FF = '{8'hFF, 2'd0, 8'h00, 1'b0};
    localparam display_beat_t UPDATED = '{8'h00, 2'd0, 8'h00, 1'b1};

    bus_event_t directed_events [] = '{
        '{REQ_SCAN,   8'h00,      1'b1, QUIET},
        '{REQ_READ,   8'h5A,      1'b1, QUIET},
        '{REQ_ADDR,   8'hFF,      1'b1, QUIET},
        '{REQ_WRITE,  POINT_REG,  1'b1, QUIET},
        '{REQ_READ,   8'h00,      1'b1, READ_FF},
        '{REQ_STOP,   8'h00,      1'b1, QUIET},
        '{REQ_ADDR,   8'h00,      1'b1, QUIET},
        '{REQ_WRITE,  VALUE_BASE, 1'b1, QUIET},
        '{REQ_WRITE,  8'hFF,      1'b1, QUIET},
        '{REQ_WRITE,  8'hFF,      1'b1, QUIET},
        '{REQ_WRITE,  8'h03,      1'b1, QUIET},
        '{REQ_STOP,   8'h00,      1'b1, UPDATED},
        '{REQ_SCAN,   8'h00,      1'b0, QUIET},
        '{REQ_SCAN,   8'h00,      1'b0, QUIET},
        '{REQ_SCAN,   8'h00,      1'b0, QUIET},
        '{REQ_ADDR,   8'h00,      1'b1, QUIET},
        '{REQ_WRITE,  VALUE_BASE, 1'b1, QUIET},
        '{REQ_WRITE,  8'h00,      1'b1, QUIET},
        '{REQ_WRITE,  8'h07,      1'b1, QUIET},
        '{REQ_WRITE,  8'h00,      1'b1, QUIET},
        '{REQ_STOP,   8'h00,      1'b1, UPDATED},
        '{REQ_SCAN,   8'h00,      1'b0, QUIET},
        '{REQ_ADDR,   8'h00,      1'b1, QUIET},
        '{REQ_WRITE,  8'hFF,      1'b1, QUIET},
        '{REQ_WRITE,  8'hAA,      1'b1, QUIET},
        '{REQ_READ,   8'h00,      1'b1, QUIET},
        '{REQ_READ,   8'h00,      1'b1, QUIET},
        '{REQ_STOP,   8'h00,      1'b1, QUIET},
        '{REQ_UNUSED, 8'hFF,      1'b1, QUIET}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic [2:0]  s_tuser;   // [2:0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] read_data, [15:8] segment_bits
    logic [2:0]  m_tuser;   // [1:0] digit_index, [2] display_updated

    bus_event_t    event_q [$];
    display_beat_t expected_q [$];
    bus_event_t    cur_event;
    int            error_count = 0;
    int            cycle_count = 0;

    logic [7:0] shadow_regs [FILE_DEPTH];
    logic [7:0] shadow_ptr;
    logic [7:0] shadow_start;
    logic [7:0] shadow_count;
    logic       shadow_armed;
    logic       shadow_wseen;
    logic [1:0] shadow_scan;

    i2c_seven_segment_register_target_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("tb NOT OK");
        $finish;
    end

    task automatic clear_shadow();
        for (int i = 0; i < FILE_DEPTH; i++)
            shadow_regs[i] = 8'h00;
        shadow_regs[POINT_REG] = POINT_RESET;
        shadow_ptr   = 8'h00;
        shadow_start = 8'h00;
        shadow_count = 8'h00;
        shadow_armed = 1'b1;
        shadow_wseen = 1'b0;
        shadow_scan  = 2'd0;
    endtask

    function automatic void refresh_digits();
        int         value;
        int         thou;
        logic [7:0] point;
        value = {shadow_regs[VALUE_BASE], shadow_regs[VALUE_BASE + 8'd1]};
        thou  = value / 1000;
        point = shadow_regs[POINT_REG];
        shadow_regs[0] = DIGIT_SEGMENTS[value % 10];
        shadow_regs[1] = (value >= 10) ? DIGIT_SEGMENTS[(value / 10) % 10] : 8'h00;
        shadow_regs[2] = (value >= 100) ? DIGIT_SEGMENTS[(value / 100) % 10] : 8'h00;
        // thousands above nine: keep old pattern, only the point moves
        if (value < 1000)
            shadow_regs[3] = 8'h00;
        else if (thou < 10)
            shadow_regs[3] = DIGIT_SEGMENTS[thou];
        for (int i = 0; i < DIGIT_COUNT; i++)
            shadow_regs[i][7] = (point == i);
    endfunction

    function automatic display_beat_t predict_display_beat(input logic [2:0] req,
                                                           input logic [7:0] data);
        display_beat_t r;
        r = '0;
        case (req)
            REQ_ADDR:
            begin
                shadow_armed = 1'b1;
                shadow_wseen = 1'b0;
            end
            REQ_WRITE:
            begin
                if (shadow_armed)
                begin
                    shadow_ptr   = data;
                    shadow_start = data;
                    shadow_count = 8'h00;
                    shadow_armed = 1'b0;
                    shadow_wseen = 1'b1;
                end
                else if (shadow_ptr < FILE_DEPTH)
                begin
                    shadow_regs[shadow_ptr] = data;
                    if (shadow_ptr != PTR_TOP)
                        shadow_ptr = shadow_ptr + 8'd1;
                    if (shadow_count != 8'hFF)
                        shadow_count = shadow_count + 8'd1;
                end
            end
            REQ_READ:
            begin
                if (shadow_ptr < FILE_DEPTH)
                    r.read_data = shadow_regs[shadow_ptr];
                if (shadow_ptr != PTR_TOP)
                    shadow_ptr = shadow_ptr + 8'd1;
            end
            REQ_STOP:
            begin
                if (shadow_wseen && shadow_start == VALUE_BASE && shadow_count != 8'h00)
                begin
                    refresh_digits();
                    r.display_updated = 1'b1;
                end
                shadow_wseen = 1'b0;
                shadow_armed = 1'b1;
            end
            REQ_SCAN:
            begin
                r.digit_index  = shadow_scan;
                r.segment_bits = shadow_regs[shadow_scan];
                shadow_scan    = shadow_scan + 2'd1;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic push_event(input logic [2:0] req, input logic [7:0] data);
        bus_event_t ev;
        ev = '{req, data, 1'b0, QUIET};
        event_q.push_back(ev);
    endtask

    function automatic logic [7:0] pick_write_byte(input int pos);
        if (pos == VALUE_BASE || pos == VALUE_BASE + 1)
        begin
            case ($urandom_range(0, 3))
                0:       return 8'h00;
                1:       return 8'($urandom_range(0, 15));
                2:       return 8'($urandom_range(0, 39));
                default: return 8'($urandom);
            endcase
        end
        if (pos == POINT_REG)
        begin
            case ($urandom_range(0, 5))
                4:       return POINT_RESET;
                5:       return 8'($urandom);
                default: return 8'($urandom_range(0, 3));
            endcase
        end
        return 8'($urandom);
    endfunction

    task automatic add_write_burst();
        logic [7:0] ptr;
        int         n;
        if ($urandom_range(0, 3) != 0)
            push_event(REQ_ADDR, 8'($urandom));
        case ($urandom_range(0, 9))
            5:       ptr = POINT_REG;
            6:       ptr = 8'($urandom_range(0, 3));
            7:       ptr = 8'($urandom_range(0, 31));
            8:       ptr = 8'($urandom_range(28, 31));
            9:       ptr = 8'($urandom);
            default: ptr = VALUE_BASE;
        endcase
        push_event(REQ_WRITE, ptr);
        n = $urandom_range(0, 5);
        for (int k = 0; k < n; k++)
            push_event(REQ_WRITE, pick_write_byte(ptr + k));
        if ($urandom_range(0, 9) != 0)
            push_event(REQ_STOP, 8'($urandom));
    endtask

    task automatic add_read_burst();
        int n;
        push_event(REQ_ADDR, 8'($urandom));
        if ($urandom_range(0, 1) != 0)
        begin
            if ($urandom_range(0, 3) == 0)
                push_event(REQ_WRITE, 8'($urandom));
            else
                push_event(REQ_WRITE, 8'($urandom_range(0, 35)));
            push_event(REQ_ADDR, 8'($urandom));
        end
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++)
            push_event(REQ_READ, 8'($urandom));
        push_event(REQ_STOP, 8'($urandom));
    endtask

    function automatic int pick_idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s expected %0h got %0h", $time, field, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        display_beat_t got;
        display_beat_t want;
        display_beat_t pred;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[7:0], m_tuser[1:0], m_tdata[15:8], m_tuser[2]};
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none got %h",
                             $time, got);
                    error_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("digit_index", want.digit_index, got.digit_index);
                    check_field("segment_bits", want.segment_bits, got.segment_bits);
                    check_field("display_updated", want.display_updated,
                                got.display_updated);
                end
            end
            if (s_tvalid && s_tready)
            begin
                pred = predict_display_beat(cur_event.req, cur_event.data);
                expected_q.push_back(cur_event.fixed ? cur_event.res : pred);
            end
        end
    end

    initial
    begin
        int stall;
        int run;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = pick_idle_cycles();
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            if ($urandom_range(0, 19) == 0)
                run = $urandom_range(100, 300);
            else
                run = $urandom_range(1, 8);
            repeat (run) @(negedge clk);
        end
    end

    initial
    begin
        bus_event_t ev;
        int         gap;
        int         calm_left;
        int         total;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tuser   = 3'd0;
        cur_event = '0;
        rst_n     = 1'b0;
        calm_left = 0;
        clear_shadow();
        foreach (directed_events[i])
            event_q.push_back(directed_events[i]);
        total = event_q.size() + RANDOM_ITEMS;
        while (event_q.size() < total)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: add_write_burst();
                9, 10, 11, 12, 13:         add_read_burst();
                14, 15, 16, 17:
                    repeat ($urandom_range(1, 6)) push_event(REQ_SCAN, 8'($urandom));
                default: push_event(3'($urandom_range(0, 7)), 8'($urandom));
            endcase
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        while (event_q.size() > 0)
        begin
            ev = event_q.pop_front();
            if (calm_left == 0 && $urandom_range(0, 49) == 0)
                calm_left = $urandom_range(20, 60);
            if (calm_left > 0)
            begin
                gap = 0;
                calm_left--;
            end
            else
                gap = pick_idle_cycles();
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid  = 1'b1;
            s_tuser   = ev.req;
            s_tdata   = ev.data;
            cur_event = ev;
            do
                @(posedge clk);
            while (!s_tready);
            @(negedge clk);
        end
        s_tvalid = 1'b0;
        while (expected_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
